@@ hdl/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Each macro expects signals named clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PIDL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Implication checked in the cycle after the antecedent.
`define PIDL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/pidl_pkg.sv @@
package pidl_pkg;

	// request opcodes
	localparam logic [2:0] OP_INS_START = 3'd0;
	localparam logic [2:0] OP_INS_POS   = 3'd1;
	localparam logic [2:0] OP_INS_END   = 3'd2;
	localparam logic [2:0] OP_DEL_START = 3'd3;
	localparam logic [2:0] OP_DEL_POS   = 3'd4;
	localparam logic [2:0] OP_DEL_END   = 3'd5;
	localparam logic [2:0] OP_SEARCH    = 3'd6;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_BADPOS   = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	localparam int VAL_W  = 32;
	localparam int POS_W  = 5;
	localparam int FIDX_W = 4;
	localparam int CNT_W  = 5;
	localparam int GRP_W  = 16; // match bits looked at per scan cycle

	// per-cell load select
	typedef struct packed {
		logic take_new;   // load the request value
		logic take_left;  // load lower neighbour (insert shift)
		logic take_right; // load upper neighbour (delete shift)
	} cell_ctrl_t;

endpackage

@@ hdl/pidl_cell.sv @@
module pidl_cell (
	input  logic                       clk,
	input  pidl_pkg::cell_ctrl_t       ctrl,
	input  logic [pidl_pkg::VAL_W-1:0] new_val,
	input  logic [pidl_pkg::VAL_W-1:0] left_val,
	input  logic [pidl_pkg::VAL_W-1:0] right_val,
	input  logic [pidl_pkg::VAL_W-1:0] cmp_val,
	input  logic                       in_use,
	output logic [pidl_pkg::VAL_W-1:0] val,
	output logic                       match
);
	import pidl_pkg::*;

	logic [VAL_W-1:0] val_q;

	// selects are mutually exclusive; with none set the cell holds
	always_ff @(posedge clk) begin
		if (ctrl.take_new) begin
			val_q <= new_val;
		end else if (ctrl.take_left) begin
			val_q <= left_val;
		end else if (ctrl.take_right) begin
			val_q <= right_val;
		end
	end

	assign val   = val_q;
	assign match = in_use && (val_q == cmp_val);

endmodule

@@ hdl/pidl_scan.sv @@
module pidl_scan #(
	parameter int NG = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [NG*pidl_pkg::GRP_W-1:0] match_in,
	output logic                          hit,
	output logic                          last,
	output logic [((NG > 1) ? $clog2(NG) : 1)+3:0] idx
);
	import pidl_pkg::*;

	localparam int GW = (NG > 1) ? $clog2(NG) : 1;

	logic [NG*GRP_W-1:0] match_q;
	logic [GW-1:0]       grp_q;
	logic [GRP_W-1:0]    cur;
	logic [3:0]          pe;

	assign cur = match_q[grp_q*GRP_W +: GRP_W];

	// lowest set bit of the current group
	always_comb begin
		pe = '0;
		for (int b = GRP_W - 1; b >= 0; b--) begin
			if (cur[b]) begin
				pe = 4'(b);
			end
		end
	end

	assign hit  = |cur;
	assign last = (grp_q == GW'(NG - 1));
	assign idx  = {grp_q, pe};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= '0;
		end else if (load) begin
			grp_q <= '0;
		end else if (!hit && !last) begin
			grp_q <= grp_q + GW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			match_q <= match_in;
		end
	end

endmodule

@@ hdl/positional_insert_delete_list_core.sv @@
// Positional insert/delete list: an ordered, packed list of signed 32-bit
// values, CAPACITY entries deep, held in a row of cells.
// Input channel s_*: one request item per handshake (opcode, position, value).
// Output channel m_*: exactly one result item per request (status, found
//   index, count after the request), in request order.
// Timing: a request is taken in IDLE, applied to every cell at once in the
//   next cycle (EXEC), and its result is loaded into the output register in
//   DONE. Insert, delete and no-op go from EXEC straight to DONE; search
//   passes the first-match scan (SCAN) between them, which inspects 16 cell
//   match bits per cycle.
// One request is in flight at a time; s_tready is high only in IDLE.
// A result waiting in the output register does not block the next request;
// only loading the following result waits for m_tready.
// Reset: the count and all control clear at once; cell contents are left
// as they are, since only entries below the count are ever read.
module positional_insert_delete_list_core #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // opcode[2:0], position[7:3], value[39:8]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // status[2:0], found_index[6:3], count[11:7], zero[15:12]
);
	import pidl_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);       // count width
	localparam int WW = (CW > POS_W) ? CW : POS_W;  // compare width
	localparam int NG = (CAPACITY + GRP_W - 1) / GRP_W;
	localparam int GW = (NG > 1) ? $clog2(NG) : 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]       state_q;
	logic [CW-1:0]    count_q;

	// latched request
	logic [2:0]       op_q;
	logic [POS_W-1:0] pos_q;
	logic [VAL_W-1:0] val_q;

	// pending result
	logic [2:0]        res_status_q;
	logic [FIDX_W-1:0] res_fidx_q;

	logic              m_tvalid_q;
	logic [15:0]       m_tdata_q;

	// request decode
	logic [WW-1:0]  pos_w, cnt_w, cap_w, k_w;
	logic           do_ins, do_del;
	logic [2:0]     ex_status;
	logic [CW-1:0]  count_nx;

	// cell row
	logic [VAL_W-1:0]      cell_val [CAPACITY];
	logic [NG*GRP_W-1:0]   match_vec;

	// scan unit
	logic            scan_load, scan_hit, scan_last;
	logic [GW+3:0]   scan_idx;

	logic [WW-1:0]   cnt_out_w;

	assign s_tready = (state_q == S_IDLE);

	assign pos_w = WW'(pos_q);
	assign cnt_w = WW'(count_q);
	assign cap_w = WW'(CAPACITY);

	always_comb begin
		do_ins    = 1'b0;
		do_del    = 1'b0;
		k_w       = '0;
		ex_status = ST_OK;
		unique case (op_q)
			OP_INS_START, OP_INS_POS, OP_INS_END: begin
				unique case (op_q)
					OP_INS_START: k_w = '0;
					OP_INS_END:   k_w = cnt_w;
					default:      k_w = pos_w;
				endcase
				priority if (cnt_w >= cap_w) begin
					ex_status = ST_FULL;
				end else if (op_q == OP_INS_POS && pos_w > cnt_w) begin
					ex_status = ST_BADPOS;
				end else begin
					do_ins = 1'b1;
				end
			end
			OP_DEL_START, OP_DEL_POS, OP_DEL_END: begin
				unique case (op_q)
					OP_DEL_START: k_w = '0;
					OP_DEL_END:   k_w = cnt_w - WW'(1);
					default:      k_w = pos_w;
				endcase
				priority if (cnt_w == '0) begin
					ex_status = ST_EMPTY;
				end else if (op_q == OP_DEL_POS && pos_w >= cnt_w) begin
					ex_status = ST_BADPOS;
				end else begin
					do_del = 1'b1;
				end
			end
			default: ex_status = ST_OK; // search settles its status in the scan; the spare opcode reports ok
		endcase
	end

	always_comb begin
		priority if (do_ins) begin
			count_nx = count_q + CW'(1);
		end else if (do_del) begin
			count_nx = count_q - CW'(1);
		end else begin
			count_nx = count_q;
		end
	end

	// Row of cells: every cell sees the same decoded request and picks its
	// own source, so a whole shift happens in the EXEC cycle.
	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			cell_ctrl_t       ctrl;
			logic [VAL_W-1:0] left_v, right_v;
			logic             in_use;

			assign left_v  = (i == 0) ? '0 : cell_val[(i == 0) ? 0 : i - 1];
			assign right_v = (i == CAPACITY - 1) ? cell_val[i]
			                 : cell_val[(i == CAPACITY - 1) ? i : i + 1];
			assign in_use  = (WW'(i) < cnt_w);

			always_comb begin
				ctrl.take_new   = (state_q == S_EXEC) && do_ins && (k_w == WW'(i));
				ctrl.take_left  = (state_q == S_EXEC) && do_ins && (WW'(i) > k_w);
				ctrl.take_right = (state_q == S_EXEC) && do_del && (WW'(i) >= k_w);
			end

			pidl_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.new_val   (val_q),
				.left_val  (left_v),
				.right_val (right_v),
				.cmp_val   (val_q),
				.in_use    (in_use),
				.val       (cell_val[i]),
				.match     (match_vec[i])
			);
		end
		if (NG * GRP_W > CAPACITY) begin : g_pad
			assign match_vec[NG*GRP_W-1:CAPACITY] = '0;
		end
	endgenerate

	assign scan_load = (state_q == S_EXEC) && (op_q == OP_SEARCH);

	pidl_scan #(
		.NG (NG)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (scan_load),
		.match_in (match_vec),
		.hit      (scan_hit),
		.last     (scan_last),
		.idx      (scan_idx)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					count_q <= count_nx;
					state_q <= (op_q == OP_SEARCH) ? S_SCAN : S_DONE;
				end
				S_SCAN: begin
					if (scan_hit || scan_last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= s_tdata[2:0];
			pos_q <= s_tdata[7:3];
			val_q <= s_tdata[39:8];
		end
		if (state_q == S_EXEC) begin
			res_status_q <= ex_status;
			res_fidx_q   <= '0;
		end else if (state_q == S_SCAN && (scan_hit || scan_last)) begin
			res_status_q <= scan_hit ? ST_OK : ST_NOTFOUND;
			res_fidx_q   <= scan_hit ? scan_idx[FIDX_W-1:0] : '0;
		end
	end

	assign cnt_out_w = WW'(count_q);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {4'd0, cnt_out_w[CNT_W-1:0], res_fidx_q, res_status_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ hdl/pidl_checker.sv @@
`include "assert_macros.svh"

module pidl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);
	import pidl_pkg::*;

	// a held result keeps its contents
	`PIDL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// only one request in flight: no accept straight after an accept
	`PIDL_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "request taken while busy")

	// status codes stay in range
	`PIDL_ASSERT(a_status_range, !m_tvalid || m_tdata[2:0] <= ST_NOTFOUND, "bad status code")

	// a found index only comes with a successful status
	`PIDL_ASSERT(a_fidx_ok, !m_tvalid || m_tdata[6:3] == 4'd0 || m_tdata[2:0] == ST_OK, "index without ok status")

	// an empty report means the list holds nothing
	`PIDL_ASSERT(a_empty_cnt, !m_tvalid || m_tdata[2:0] != ST_EMPTY || m_tdata[11:7] == 5'd0, "empty with entries")

endmodule

bind positional_insert_delete_list_core pidl_checker u_pidl_checker (.*);

@@ tb/sv/pidl_result_checker.sv @@
`timescale 1ns / 100ps

// Watches both streams, keeps a mirror of the list and checks every result item.
module pidl_result_checker
	import pidl_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	output int          fail_count,
	output int          outstanding,
	output int          results_checked,
	output int          full_hits,
	output int          empty_hits,
	output int          badpos_hits,
	output int          notfound_hits
);

	typedef struct packed {
		logic [2:0]        status;
		logic [FIDX_W-1:0] found_index;
		logic [CNT_W-1:0]  count;
	} list_result_t;

	logic [VAL_W-1:0] mirror_vals [CAPACITY];
	int               mirror_len;
	list_result_t     results_due [$];
	list_result_t     want;
	list_result_t     got;

	// applies one request to the mirror and returns the result it should give
	function automatic list_result_t list_apply(input logic [2:0] op,
			input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] val);
		list_result_t r;
		int           at;
		int           i;
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_INS_START, OP_INS_POS, OP_INS_END: begin
				if (mirror_len >= CAPACITY) begin
					r.status = ST_FULL;
				end else if (op == OP_INS_POS && int'(pos) > mirror_len) begin
					r.status = ST_BADPOS;
				end else begin
					at = (op == OP_INS_START) ? 0 : (op == OP_INS_END) ? mirror_len : int'(pos);
					for (i = mirror_len; i > at; i--)
						mirror_vals[i] = mirror_vals[i-1];
					mirror_vals[at] = val;
					mirror_len++;
				end
			end
			OP_DEL_START, OP_DEL_POS, OP_DEL_END: begin
				if (mirror_len == 0) begin
					r.status = ST_EMPTY;
				end else if (op == OP_DEL_POS && int'(pos) >= mirror_len) begin
					r.status = ST_BADPOS;
				end else begin
					at = (op == OP_DEL_START) ? 0 : (op == OP_DEL_END) ? mirror_len - 1 : int'(pos);
					for (i = at; i + 1 < mirror_len; i++)
						mirror_vals[i] = mirror_vals[i+1];
					mirror_len--;
				end
			end
			OP_SEARCH: begin
				r.status = ST_NOTFOUND;
				for (i = 0; i < mirror_len; i++) begin
					if (r.status == ST_NOTFOUND && mirror_vals[i] == val) begin
						r.status = ST_OK;
						r.found_index = FIDX_W'(i);
					end
				end
			end
			default: ; // spare opcode: nothing changes
		endcase
		r.count = CNT_W'(mirror_len);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_due.delete();
			mirror_len = 0;
			fail_count = 0;
			outstanding = 0;
			results_checked = 0;
			full_hits = 0;
			empty_hits = 0;
			badpos_hits = 0;
			notfound_hits = 0;
		end else begin
			// result first: it always belongs to an older request
			if (m_tvalid && m_tready) begin
				got.status      = m_tdata[2:0];
				got.found_index = m_tdata[6:3];
				got.count       = m_tdata[11:7];
				if (results_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result item with no request waiting: status %0d index %0d count %0d",
							$time, got.status, got.found_index, got.count);
				end else begin
					want = results_due.pop_front();
					results_checked++;
					case (want.status)
						ST_FULL:     full_hits++;
						ST_EMPTY:    empty_hits++;
						ST_BADPOS:   badpos_hits++;
						ST_NOTFOUND: notfound_hits++;
						default: ;
					endcase
					if (got.status != want.status || got.found_index != want.found_index
							|| got.count != want.count) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: result %0d mismatch: want status %0d index %0d count %0d, got status %0d index %0d count %0d",
								$time, results_checked, want.status, want.found_index, want.count,
								got.status, got.found_index, got.count);
					end
				end
			end
			if (s_tvalid && s_tready)
				results_due.push_back(list_apply(s_tdata[2:0], s_tdata[7:3], s_tdata[39:8]));
			outstanding = results_due.size();
		end
	end

endmodule

@@ tb/sv/positional_insert_delete_list_core_tb.sv @@
`timescale 1ns / 100ps

// Stimulus and verdict for the list core. All checking lives in the checker;
// this module only drives requests, paces the result side and judges the run.
module positional_insert_delete_list_core_tb;
	import pidl_pkg::*;

	localparam int         CAPACITY    = 16;
	localparam logic [2:0] OP_SPARE    = 3'd7; // unused opcode, behaves as a no-op
	localparam int         HOLD_CYCLES = 250;  // long receiver hold-off
	localparam int         PHASES      = 16;
	localparam int         PHASE_ITEMS = 102;

	// phase flavours: bias the mix towards filling, draining or neither
	localparam int MIX_FILL  = 0;
	localparam int MIX_EVEN  = 1;
	localparam int MIX_DRAIN = 2;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;  // opcode[2:0], position[7:3], value[39:8]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;       // status[2:0], found_index[6:3], count[11:7], zero[15:12]

	int fail_count;
	int outstanding;
	int results_checked;
	int full_hits;
	int empty_hits;
	int badpos_hits;
	int notfound_hits;

	int          requests_sent = 0;
	logic        calm = 1'b0;      // no gaps on either side while set, hold-off apart
	logic        hold_off = 1'b0;  // receiver held off completely
	int          stall_left = 0;
	logic [31:0] recent [16];      // recently inserted values, for searches that hit
	int          recent_wr = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	positional_insert_delete_list_core #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	pidl_result_checker #(
		.CAPACITY(CAPACITY)
	) result_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.full_hits       (full_hits),
		.empty_hits      (empty_hits),
		.badpos_hits     (badpos_hits),
		.notfound_hits   (notfound_hits)
	);

	// Idle length: mostly none, otherwise picked from two ranges, the longer one more rarely.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Values: a small pool gives duplicates (first-match searches), plus
	// the signed extremes and fully random words.
	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return 32'($urandom_range(0, 7));
		if (r == 4) begin
			case ($urandom_range(0, 3))
				0:       return 32'h8000_0000;
				1:       return 32'h7FFF_FFFF;
				2:       return 32'h0000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		return $urandom;
	endfunction

	// Offers one item from the falling edge and holds it until taken.
	// Valid is only dropped when a gap goes in, so it never toggles within a step.
	task automatic send_request(input logic [2:0] op, input logic [4:0] pos,
			input logic [31:0] val);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {val, pos, op};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		requests_sent++;
	endtask

	task automatic random_request(input int mix);
		int          r;
		int          ins_share;
		logic [2:0]  op;
		logic [4:0]  pos;
		logic [31:0] val;
		ins_share = (mix == MIX_FILL) ? 65 : (mix == MIX_DRAIN) ? 15 : 40;
		r = $urandom_range(0, 99);
		if (r < 2) begin
			op = OP_SPARE;
		end else if (r < 20) begin
			op = OP_SEARCH;
		end else if (r < 20 + ins_share) begin
			case ($urandom_range(0, 2))
				0:       op = OP_INS_START;
				1:       op = OP_INS_POS;
				default: op = OP_INS_END;
			endcase
		end else begin
			case ($urandom_range(0, 2))
				0:       op = OP_DEL_START;
				1:       op = OP_DEL_POS;
				default: op = OP_DEL_END;
			endcase
		end
		// mostly near the live range, sometimes anywhere in the 5-bit field
		pos = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 16));
		if (op == OP_SEARCH && $urandom_range(0, 9) < 6)
			val = recent[$urandom_range(0, 15)];
		else
			val = pick_value();
		if (op == OP_INS_START || op == OP_INS_POS || op == OP_INS_END) begin
			recent[recent_wr % 16] = val;
			recent_wr++;
		end
		send_request(op, pos, val);
	endtask

	// Result side: random stalls, none during calm phases, all-out during the hold-off, which wins over calm.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
			end else if (calm) begin
				m_tready <= 1'b1;
				stall_left = 0;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Back-pressure: once the run is under way, the receiver stops for a long
	// stretch while requests keep coming, so the core backs up onto its input.
	initial begin
		wait (requests_sent >= 300);
		@(negedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_off <= 1'b0;
	end

	// Watchdog: several times the slowest legal run.
	initial begin
		#3_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int i;
		for (i = 0; i < 16; i++)
			recent[i] = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty-list corner cases first
		send_request(OP_DEL_START, 5'd0, 32'h0);
		send_request(OP_DEL_POS, 5'd0, 32'h0);
		send_request(OP_DEL_END, 5'd0, 32'h0);
		send_request(OP_SEARCH, 5'd0, 32'h0);        // empty search, not found
		send_request(OP_SPARE, 5'd31, 32'hFFFF_FFFF); // no-op
		send_request(OP_INS_POS, 5'd1, 32'h1);       // past the end of an empty list
		// build a short list from the value extremes
		send_request(OP_INS_POS, 5'd0, 32'h8000_0000);
		send_request(OP_INS_START, 5'd0, 32'h7FFF_FFFF);
		send_request(OP_INS_END, 5'd0, 32'hFFFF_FFFF);
		send_request(OP_INS_POS, 5'd3, 32'h0);       // position equal to count appends
		send_request(OP_INS_POS, 5'd31, 32'h5);      // far out of range
		send_request(OP_SEARCH, 5'd0, 32'hFFFF_FFFF);
		send_request(OP_SEARCH, 5'd0, 32'h1234_5678); // miss on a non-empty list
		send_request(OP_DEL_POS, 5'd4, 32'h0);       // position equal to count
		send_request(OP_DEL_POS, 5'd31, 32'h0);
		send_request(OP_DEL_POS, 5'd1, 32'h0);
		send_request(OP_DEL_START, 5'd0, 32'h0);
		send_request(OP_DEL_END, 5'd0, 32'h0);

		// random phases: fill, mixed, drain, mixed... so full and empty both recur
		for (i = 0; i < PHASES; i++) begin
			calm = (i % 5 == 2);
			repeat (PHASE_ITEMS) begin
				case (i % 4)
					0:       random_request(MIX_FILL);
					2:       random_request(MIX_DRAIN);
					default: random_request(MIX_EVEN);
				endcase
			end
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		// drain: every expected result in, then a pause for strays
		while (outstanding != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("Checked %0d results for %0d requests: %0d full, %0d empty, %0d bad position, %0d not found.",
			results_checked, requests_sent, full_hits, empty_hits, badpos_hits, notfound_hits);
		$display("Run had one %0d-cycle receiver hold-off and gap-free stretches on both sides.",
			HOLD_CYCLES);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
